// ----- hw/rtl/ampf_pkg.sv -----
// Shared constants, types and the arctangent table of the IQ AM/PM/FM demodulator.
package ampf_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int RUN_STAGES    = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int GUARD_BITS    = 4;
  localparam int GROWTH_BITS   = 3;
  localparam int CORD_W        = SAMPLE_WIDTH + GUARD_BITS + GROWTH_BITS;
  localparam int STEP_W        = (RUN_STAGES > 1) ? $clog2(RUN_STAGES) : 1;

  localparam int PHASE_W    = 16;
  localparam int POWER_W    = 32;
  localparam int RATE_W     = 26;
  localparam int FM_W       = 26;
  localparam int RATE_RESET = 625000;

  localparam int MUL_AW = (SAMPLE_WIDTH > PHASE_W) ? SAMPLE_WIDTH : PHASE_W;
  localparam int MUL_BW = RATE_W + 1;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam int IN_DATA_W    = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = POWER_W + PHASE_W + FM_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [PHASE_W-1:0] PHASE_HALF_TURN = 16'h8000;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] i_sample;
    logic signed [SAMPLE_WIDTH-1:0] q_sample;
    logic                           first_of_sweep;
    logic                           zero_vector;
  } ampf_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_FREQ,
    ST_EMIT
  } ampf_state_t;

  function automatic logic [PHASE_W-1:0] atan_entry(input logic [4:0] k);
    logic [PHASE_W-1:0] a;
    case (k)
      5'd0:    a = 16'd8192;
      5'd1:    a = 16'd4836;
      5'd2:    a = 16'd2555;
      5'd3:    a = 16'd1297;
      5'd4:    a = 16'd651;
      5'd5:    a = 16'd326;
      5'd6:    a = 16'd163;
      5'd7:    a = 16'd81;
      5'd8:    a = 16'd41;
      5'd9:    a = 16'd20;
      5'd10:   a = 16'd10;
      5'd11:   a = 16'd5;
      5'd12:   a = 16'd3;
      5'd13:   a = 16'd1;
      5'd14:   a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- hw/rtl/iq_am_pm_fm_demodulator_top.sv -----
// Top level of the IQ AM/PM/FM demodulator: rate register, front end and back end.
//
// Input channel s_*: one complex sample per transfer, I in tdata[15:0], Q in
// tdata[31:16], and tuser high on the first sample of a sweep.
// Output channel m_*: one result per input, am_power in tdata[31:0],
// phase_angle in tdata[47:32] and fm_hz in tdata[73:48]; the upper bits are zero.
// cfg_wr_en with cfg_wr_data writes the sample rate in hertz into a register.
// The back end loads an item, runs it through the 16 CORDIC stages in the shared
// rotation unit, does the FM multiply and then fills the output register. It
// takes the next item only after the current one has gone to the output
// register, so sustained throughput is set by the CORDIC iteration loop and by
// receiver stalls.
// A two-entry queue in front keeps s_tready high until both entries are full,
// and the output register lets the back end finish an item while the receiver
// stalls; a stalled result holds until it is taken, then the next one loads.
// Reset empties the queue, drops m_tvalid, clears the stored phase and sets the
// sample rate to 625000 Hz.
module iq_am_pm_fm_demodulator_top
  import ampf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // i_sample, q_sample
  input  logic                  s_tuser,   // first_of_sweep
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // am_power, phase_angle, fm_hz
  input  logic                  cfg_wr_en,
  input  logic [RATE_W-1:0]     cfg_wr_data
);

  logic [RATE_W-1:0] sample_rate_hz;
  logic              q_valid;
  logic              q_ready;
  ampf_item_t        q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate_hz <= RATE_W'(RATE_RESET);
    end else if (cfg_wr_en) begin
      sample_rate_hz <= cfg_wr_data;
    end
  end

  ampf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  ampf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item),
    .sample_rate_hz (sample_rate_hz),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata)
  );

`ifndef ASSERT_OFF
  a_reset_clears_output: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |=> !q_ready)
    else $error("back end took a second item while busy");

  a_no_result_at_pickup: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared while the back end was just loading");
`endif

endmodule

// ----- hw/rtl/ampf_front.sv -----
// Input side: accepts IQ transfers, flags the zero vector and queues items for the back end.
module ampf_front
  import ampf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,   // i_sample, q_sample
  input  logic                 s_tuser,   // first_of_sweep
  output logic                 q_valid,
  input  logic                 q_ready,
  output ampf_item_t           q_item
);

  ampf_item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  ampf_item_t in_item;

  always_comb begin
    in_item.i_sample       = s_tdata[SAMPLE_WIDTH-1:0];
    in_item.q_sample       = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    in_item.first_of_sweep = s_tuser;
    in_item.zero_vector    = (s_tdata[2*SAMPLE_WIDTH-1:0] == '0);
  end

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
  end

endmodule

// ----- hw/rtl/ampf_back.sv -----
// Back end: iterative CORDIC phase, shared multiplier for power and FM, output register.
module ampf_back
  import ampf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  ampf_item_t            q_item,
  input  logic [RATE_W-1:0]     sample_rate_hz,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // am_power, phase_angle, fm_hz
);

  ampf_state_t state;
  ampf_state_t state_next;

  logic signed [SAMPLE_WIDTH-1:0] i_reg;
  logic signed [SAMPLE_WIDTH-1:0] q_reg;
  logic                           first_reg;
  logic                           zero_reg;
  logic signed [CORD_W-1:0]       x;
  logic signed [CORD_W-1:0]       y;
  logic [PHASE_W-1:0]             z;
  logic [STEP_W-1:0]              step;
  logic [POWER_W-1:0]             power;
  logic signed [MUL_PW-1:0]       prod;
  logic [PHASE_W-1:0]             prev_phase;

  logic signed [CORD_W-1:0]       x_init;
  logic signed [CORD_W-1:0]       y_init;
  logic signed [CORD_W-1:0]       x_shift;
  logic signed [CORD_W-1:0]       y_shift;
  logic [PHASE_W-1:0]             angle;
  logic                           last_step;
  logic [PHASE_W-1:0]             phase_final;
  logic [PHASE_W-1:0]             delta;
  logic signed [MUL_AW-1:0]       mul_a;
  logic signed [MUL_BW-1:0]       mul_b;
  logic signed [MUL_PW-1:0]       mul_p;
  logic                           load_out;
  logic [FM_W-1:0]                fm_value;

  assign x_init    = {{(CORD_W-SAMPLE_WIDTH-GUARD_BITS){q_item.i_sample[SAMPLE_WIDTH-1]}},
                      q_item.i_sample, {GUARD_BITS{1'b0}}};
  assign y_init    = {{(CORD_W-SAMPLE_WIDTH-GUARD_BITS){q_item.q_sample[SAMPLE_WIDTH-1]}},
                      q_item.q_sample, {GUARD_BITS{1'b0}}};
  assign x_shift   = x >>> step;
  assign y_shift   = y >>> step;
  assign angle     = atan_entry(5'(step));
  assign last_step = (step == STEP_W'(RUN_STAGES - 1));
  assign phase_final = zero_reg ? '0 : z;
  assign delta     = phase_final - prev_phase;

  always_comb begin
    if (state == ST_FREQ) begin
      mul_a = MUL_AW'(signed'(delta));
      mul_b = {1'b0, sample_rate_hz};
    end else if (step == '0) begin
      mul_a = MUL_AW'(i_reg);
      mul_b = MUL_BW'(i_reg);
    end else begin
      mul_a = MUL_AW'(q_reg);
      mul_b = MUL_BW'(q_reg);
    end
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (q_valid) state_next = ST_ROTATE;
      ST_ROTATE: if (last_step) state_next = ST_FREQ;
      ST_FREQ:   state_next = ST_EMIT;
      ST_EMIT:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready  = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: q_ready  = 1'b1;
      ST_EMIT: load_out = !m_tvalid || m_tready;
      default: begin
        q_ready  = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  assign fm_value = first_reg ? '0 : prod[16 +: FM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      prev_phase <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FREQ) begin
        prev_phase <= phase_final;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        i_reg     <= q_item.i_sample;
        q_reg     <= q_item.q_sample;
        first_reg <= q_item.first_of_sweep;
        zero_reg  <= q_item.zero_vector;
        step      <= '0;
        if (q_item.i_sample[SAMPLE_WIDTH-1]) begin
          x <= -x_init;
          y <= -y_init;
          z <= PHASE_HALF_TURN;
        end else begin
          x <= x_init;
          y <= y_init;
          z <= '0;
        end
      end
      ST_ROTATE: begin
        if (!y[CORD_W-1]) begin
          x <= x + y_shift;
          y <= y - x_shift;
          z <= z + angle;
        end else begin
          x <= x - y_shift;
          y <= y + x_shift;
          z <= z - angle;
        end
        step <= step + STEP_W'(1);
        prod <= mul_p;
        if (step == STEP_W'(1)) begin
          power <= prod[POWER_W-1:0];
        end else if (step == STEP_W'(2)) begin
          power <= power + prod[POWER_W-1:0];
        end
      end
      ST_FREQ: begin
        prod <= mul_p;
        z    <= phase_final;
      end
      default: begin
        if (load_out) begin
          m_tdata <= {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, fm_value, z, power};
        end
      end
    endcase
  end

endmodule
